// ===== sv/jscan_pkg.sv =====
// Shared types, constants and the TMS word function for the JTAG scan builder.
// Used by jscan_front, jscan_fifo, jscan_back and jtag_ir_dr_scan_builder.
package jscan_pkg;

    localparam int LEN_W  = 13;
    localparam int POS_W  = 8;
    localparam int WORD_W = 32;
    localparam int SKIP_W = 3;
    localparam int ADDR_W = 14;

    localparam logic [WORD_W-1:0] TMS_PREFIX_IR = 32'h6;
    localparam logic [WORD_W-1:0] TMS_PREFIX_DR = 32'h2;
    localparam logic [1:0]        TMS_TAIL      = 2'h3;
    localparam logic [SKIP_W-1:0] PRE_IR        = 3'd5;
    localparam logic [SKIP_W-1:0] PRE_DR        = 3'd4;

    // One classified data word, passed from the front part to the back part.
    typedef struct packed {
        logic              ir;
        logic [LEN_W-1:0]  len;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] tdi;
        logic [4:0]        spill;
        logic              fin;
        logic              two;
        logic              rb;
        logic              sn;
    } scan_entry_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

    // TMS bits of word k; a is the absolute position of the last data bit.
    function automatic logic [WORD_W-1:0] tms_at(input logic [POS_W:0] k,
                                                 input logic [ADDR_W-1:0] a,
                                                 input logic ir);
        logic [WORD_W-1:0] w;
        logic [ADDR_W-1:0] a1;
        w  = '0;
        a1 = a + ADDR_W'(1);
        if (k == '0)
        begin
            w = ir ? TMS_PREFIX_IR : TMS_PREFIX_DR;
        end
        if (a[ADDR_W-1:5] == k)
        begin
            w = w | (WORD_W'(TMS_TAIL[0]) << a[4:0]);
        end
        if (a1[ADDR_W-1:5] == k)
        begin
            w = w | (WORD_W'(TMS_TAIL[1]) << a1[4:0]);
        end
        return w;
    endfunction

endpackage

// ===== sv/jscan_front.sv =====
// Front part of the scan builder: accepts data words, clamps the length, masks
// and shifts the data, and tracks the word counter and carry bits. Uses jscan_pkg.
module jscan_front #(
    parameter int MAX_SEQ_BITS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic [jscan_pkg::LEN_W-1:0]  seq_bits,
    input  logic [jscan_pkg::WORD_W-1:0] data_word,
    input  logic                      tdo_capture,
    input  logic                      send_now,
    input  logic                      q_full,
    output logic                      q_push,
    output jscan_pkg::scan_entry_t    q_entry
);
    import jscan_pkg::*;

    localparam logic [16:0] MAX_LEN = 17'(MAX_SEQ_BITS);

    logic [POS_W-1:0]  word_counter_reg, word_counter_next;
    logic [4:0]        carry_reg, carry_next;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos_bits;
    logic [LEN_W-1:0]  valid_bits;
    logic [POS_W:0]    dwords;
    logic [POS_W:0]    twords;
    logic [POS_W:0]    pos_inc;
    logic [ADDR_W-1:0] total;
    logic [SKIP_W-1:0] pre;
    logic [WORD_W-1:0] masked;
    logic [4:0]        spill;
    logic              fin;
    logic              accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    always_comb
    begin
        if (seq_bits == '0)
        begin
            len = LEN_W'(1);
        end
        else if (17'(seq_bits) > MAX_LEN)
        begin
            len = MAX_LEN[LEN_W-1:0];
        end
        else
        begin
            len = seq_bits;
        end
    end

    assign pre      = func ? PRE_IR : PRE_DR;
    assign pos_bits = {word_counter_reg, 5'b0};
    assign pos_inc  = {1'b0, word_counter_reg} + (POS_W+1)'(1);
    assign dwords   = (POS_W+1)'((ADDR_W'(len) + ADDR_W'(31)) >> 5);
    assign total    = ADDR_W'(len) + ADDR_W'(pre) + ADDR_W'(2);
    assign twords   = (POS_W+1)'((total + ADDR_W'(31)) >> 5);
    assign fin      = pos_inc >= dwords;

    always_comb
    begin
        valid_bits = (pos_bits < len) ? (len - pos_bits) : '0;
        if (valid_bits >= LEN_W'(32))
        begin
            masked = data_word;
        end
        else if (valid_bits == '0)
        begin
            masked = '0;
        end
        else
        begin
            masked = data_word & ((WORD_W'(1) << valid_bits[4:0]) - WORD_W'(1));
        end
    end

    // Bits pushed out of the top by the prefix shift go into the next word.
    assign spill = func ? masked[31:27] : {1'b0, masked[31:28]};

    always_comb
    begin
        q_entry.ir    = func;
        q_entry.len   = len;
        q_entry.pos   = word_counter_reg;
        q_entry.tdi   = (masked << pre) | WORD_W'(carry_reg);
        q_entry.spill = spill;
        q_entry.fin   = fin;
        q_entry.two   = fin && (twords > pos_inc);
        q_entry.rb    = tdo_capture;
        q_entry.sn    = send_now;
    end

    always_comb
    begin
        word_counter_next = word_counter_reg;
        carry_next        = carry_reg;
        if (accept)
        begin
            if (fin)
            begin
                word_counter_next = '0;
                carry_next        = '0;
            end
            else
            begin
                word_counter_next = pos_inc[POS_W-1:0];
                carry_next        = spill;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_counter_reg <= '0;
            carry_reg        <= '0;
        end
        else
        begin
            word_counter_reg <= word_counter_next;
            carry_reg        <= carry_next;
        end
    end

    a_fin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fin |=> word_counter_reg == '0 && carry_reg == '0)
        else $error("final word did not restart the scan state");

    a_counter_steps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !fin |=> word_counter_reg == $past(word_counter_reg) + POS_W'(1))
        else $error("word counter did not advance by one");

endmodule

// ===== sv/jscan_fifo.sv =====
// Two-entry queue of classified scan words between the front and back parts.
// Uses jscan_pkg for the entry type.
module jscan_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  jscan_pkg::scan_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output jscan_pkg::scan_entry_t head,
    output logic                   not_empty
);
    import jscan_pkg::*;

    scan_entry_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !not_empty))
        else $error("queue pushed when full or popped when empty");

endmodule

// ===== sv/jscan_back.sv =====
// Back part of the scan builder: turns each queued word into one or two output
// beats, builds the TMS word and the scan totals, and holds the output register.
// Uses jscan_pkg.
module jscan_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  jscan_pkg::scan_entry_t       head,
    input  logic                         not_empty,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [jscan_pkg::WORD_W-1:0] tms_word,
    output logic [jscan_pkg::WORD_W-1:0] tdi_word,
    output logic [jscan_pkg::POS_W-1:0]  word_pos,
    output logic [jscan_pkg::LEN_W-1:0]  total_bits,
    output logic [jscan_pkg::SKIP_W-1:0] tdo_skip,
    output logic [jscan_pkg::LEN_W-1:0]  tdo_count,
    output logic                         flush_now,
    output logic                         last
);
    import jscan_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] tms_reg, tdi_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  total_reg, count_reg;
    logic [SKIP_W-1:0] skip_reg;
    logic              flush_reg, last_reg;

    logic              load;
    logic [SKIP_W-1:0] pre;
    logic [ADDR_W-1:0] tail_pos;
    logic [POS_W:0]    k;
    logic [WORD_W-1:0] tdi_sel;
    logic              last_sel;

    assign load     = not_empty && (!out_valid_reg || out_ready);
    assign pre      = head.ir ? PRE_IR : PRE_DR;
    assign tail_pos = ADDR_W'(head.len) + ADDR_W'(pre) - ADDR_W'(1);

    always_comb
    begin
        unique case (phase_reg)
            PH_FIRST:
            begin
                k        = {1'b0, head.pos};
                tdi_sel  = head.tdi;
                last_sel = head.fin && !head.two;
            end
            PH_SECOND:
            begin
                k        = {1'b0, head.pos} + (POS_W+1)'(1);
                tdi_sel  = WORD_W'(head.spill);
                last_sel = 1'b1;
            end
            default:
            begin
                k        = {1'b0, head.pos};
                tdi_sel  = head.tdi;
                last_sel = 1'b0;
            end
        endcase
    end

    // A word that spills into one more output word stays at the head for two beats.
    always_comb
    begin
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (phase_reg == PH_FIRST && head.two)
            begin
                phase_next = PH_SECOND;
            end
            else
            begin
                phase_next = PH_FIRST;
                pop        = 1'b1;
            end
        end
    end

    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tms_reg   <= tms_at(k, tail_pos, head.ir);
            tdi_reg   <= tdi_sel;
            pos_reg   <= k[POS_W-1:0];
            total_reg <= LEN_W'(tail_pos + ADDR_W'(3));
            skip_reg  <= head.rb ? pre : '0;
            count_reg <= head.rb ? head.len : '0;
            flush_reg <= head.sn;
            last_reg  <= last_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tms_word   = tms_reg;
    assign tdi_word   = tdi_reg;
    assign word_pos   = pos_reg;
    assign total_bits = total_reg;
    assign tdo_skip   = skip_reg;
    assign tdo_count  = count_reg;
    assign flush_now  = flush_reg;
    assign last       = last_reg;

    a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SECOND |-> not_empty)
        else $error("second beat pending with no queued word");

    a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        load && phase_reg == PH_SECOND |=> out_valid_reg && last_reg)
        else $error("spill beat not marked as the final beat");

endmodule

// ===== sv/jtag_ir_dr_scan_builder.sv =====
// Top level of the JTAG IR/DR scan builder: front part, queue and back part.
// Depends on jscan_pkg, jscan_front, jscan_fifo and jscan_back.

// The block takes the data of one Shift-IR or Shift-DR scan as 32-bit words,
// lowest bit first, and gives packed TMS and TDI words for the whole scan:
// the TMS prefix, the data shifted past it and the two-bit exit tail. Every
// data word yields one output beat, and the final word of a scan yields two
// when the tail spills into one more word. Input words are taken one per
// cycle while the queue is not full; the output register and the single
// back-end beat per cycle, while out_ready is high, set the throughput. A
// word is registered in a two-entry queue and then in the output register;
// the queue lets the input keep flowing while the output side is stalled.
module jtag_ir_dr_scan_builder #(
    parameter int MAX_SEQ_BITS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [jscan_pkg::LEN_W-1:0]  seq_bits,
    input  logic [jscan_pkg::WORD_W-1:0] data_word,
    input  logic                         tdo_capture,
    input  logic                         send_now,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [jscan_pkg::WORD_W-1:0] tms_word,
    output logic [jscan_pkg::WORD_W-1:0] tdi_word,
    output logic [jscan_pkg::POS_W-1:0]  word_pos,
    output logic [jscan_pkg::LEN_W-1:0]  total_bits,
    output logic [jscan_pkg::SKIP_W-1:0] tdo_skip,
    output logic [jscan_pkg::LEN_W-1:0]  tdo_count,
    output logic                         flush_now,
    output logic                         last
);
    import jscan_pkg::*;

    scan_entry_t q_entry;
    scan_entry_t q_head;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;

    jscan_front #(
        .MAX_SEQ_BITS(MAX_SEQ_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .seq_bits   (seq_bits),
        .data_word  (data_word),
        .tdo_capture(tdo_capture),
        .send_now   (send_now),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    jscan_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    jscan_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tms_word  (tms_word),
        .tdi_word  (tdi_word),
        .word_pos  (word_pos),
        .total_bits(total_bits),
        .tdo_skip  (tdo_skip),
        .tdo_count (tdo_count),
        .flush_now (flush_now),
        .last      (last)
    );

endmodule

// ===== tb/jscan_beat_checker.sv =====
// Checker for the JTAG IR/DR scan builder: watches both channels, predicts the
// TMS/TDI beats of every accepted data word and compares them as they leave.
// Depends on jscan_pkg for widths and the TMS prefix constants.
`timescale 1ns / 1ps

module jscan_beat_checker #(
    parameter int MAX_LEN = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         func,
    input  logic [jscan_pkg::LEN_W-1:0]  seq_bits,
    input  logic [jscan_pkg::WORD_W-1:0] data_word,
    input  logic                         tdo_capture,
    input  logic                         send_now,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [jscan_pkg::WORD_W-1:0] tms_word,
    input  logic [jscan_pkg::WORD_W-1:0] tdi_word,
    input  logic [jscan_pkg::POS_W-1:0]  word_pos,
    input  logic [jscan_pkg::LEN_W-1:0]  total_bits,
    input  logic [jscan_pkg::SKIP_W-1:0] tdo_skip,
    input  logic [jscan_pkg::LEN_W-1:0]  tdo_count,
    input  logic                         flush_now,
    input  logic                         last,
    output int                           fail_count,
    output int                           beats_pending
);
    import jscan_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] tms;
        logic [WORD_W-1:0] tdi;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  total;
        logic [SKIP_W-1:0] skip;
        logic [LEN_W-1:0]  count;
        logic              flush;
        logic              last;
    } scan_beat_t;

    scan_beat_t        scan_beats_due[$];
    logic [POS_W-1:0]  next_word_idx = '0;
    logic [4:0]        spill_bits    = '0;
    int                mismatches    = 0;

    // TMS bits at word k of a scan; the tail sits at absolute bit positions.
    function automatic logic [WORD_W-1:0] tms_bits_at(input int k, input int pre,
                                                      input int len, input logic ir);
        logic [WORD_W-1:0] w;
        int                a;
        a = pre + len - 1;
        w = '0;
        if (k == 0)
        begin
            w = ir ? TMS_PREFIX_IR : TMS_PREFIX_DR;
        end
        if ((a >> 5) == k)
        begin
            w = w | (WORD_W'(TMS_TAIL[0]) << (a % 32));
        end
        if (((a + 1) >> 5) == k)
        begin
            w = w | (WORD_W'(TMS_TAIL[1]) << ((a + 1) % 32));
        end
        return w;
    endfunction

    function automatic void predict_scan_word(input logic ir, input logic [LEN_W-1:0] len_in,
                                              input logic [WORD_W-1:0] data,
                                              input logic rb, input logic sn);
        int                len;
        int                pre;
        int                data_words;
        int                total;
        int                total_words;
        int                pos;
        int                live_bits;
        logic              fin;
        logic [WORD_W-1:0] kept;
        scan_beat_t        beat;
        len = int'(len_in);
        if (len == 0)
        begin
            len = 1;
        end
        if (len > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        pre         = ir ? int'(PRE_IR) : int'(PRE_DR);
        data_words  = (len + 31) / 32;
        total       = pre + len + 2;
        total_words = (total + 31) / 32;
        pos         = int'(next_word_idx);
        fin         = (pos + 1) >= data_words;
        live_bits   = (pos * 32 < len) ? len - pos * 32 : 0;
        // Bits beyond the scan length never reach TDI.
        if (live_bits >= 32)
        begin
            kept = data;
        end
        else if (live_bits == 0)
        begin
            kept = '0;
        end
        else
        begin
            kept = data & ((WORD_W'(1) << live_bits) - WORD_W'(1));
        end
        beat.tms   = tms_bits_at(pos, pre, len, ir);
        beat.tdi   = (kept << pre) | WORD_W'(spill_bits);
        beat.pos   = POS_W'(pos);
        beat.total = LEN_W'(total);
        beat.skip  = rb ? SKIP_W'(pre) : '0;
        beat.count = rb ? LEN_W'(len) : '0;
        beat.flush = sn;
        beat.last  = 1'b0;
        if (fin)
        begin
            if (total_words > pos + 1)
            begin
                scan_beats_due.push_back(beat);
                beat.tms  = tms_bits_at(pos + 1, pre, len, ir);
                beat.tdi  = kept >> (32 - pre);
                beat.pos  = POS_W'(pos + 1);
                beat.last = 1'b1;
            end
            else
            begin
                beat.last = 1'b1;
            end
            scan_beats_due.push_back(beat);
            next_word_idx = '0;
            spill_bits    = '0;
        end
        else
        begin
            scan_beats_due.push_back(beat);
            next_word_idx = POS_W'(pos + 1);
            spill_bits    = 5'(kept >> (32 - pre));
        end
    endfunction

    function automatic void check_beat();
        scan_beat_t seen;
        scan_beat_t want;
        seen = '{tms: tms_word, tdi: tdi_word, pos: word_pos, total: total_bits,
                 skip: tdo_skip, count: tdo_count, flush: flush_now, last: last};
        if (scan_beats_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected beat: tms %h tdi %h pos %0d", seen.tms, seen.tdi,
                         seen.pos);
            end
        end
        else
        begin
            want = scan_beats_due.pop_front();
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("beat mismatch at %0t (expected / actual):", $realtime);
                    $display("  tms %h / %h  tdi %h / %h  pos %0d / %0d", want.tms,
                             seen.tms, want.tdi, seen.tdi, want.pos, seen.pos);
                    $display("  total %0d / %0d  skip %0d / %0d  count %0d / %0d",
                             want.total, seen.total, want.skip, seen.skip, want.count,
                             seen.count);
                    $display("  flush %b / %b  last %b / %b", want.flush, seen.flush,
                             want.last, seen.last);
                end
            end
        end
    endfunction

    // Outgoing beats are checked before the incoming word is predicted, so a
    // beat can never be matched against a word taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_word_idx = '0;
            spill_bits    = '0;
            scan_beats_due.delete();
            beats_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_beat();
            end
            if (in_valid && in_ready)
            begin
                predict_scan_word(func, seq_bits, data_word, tdo_capture, send_now);
            end
            fail_count    <= mismatches;
            beats_pending <= scan_beats_due.size();
        end
    end

endmodule

// ===== tb/tb_jtag_ir_dr_scan_builder.sv =====
// Top of the scan builder testbench: clock, reset, directed and random scans,
// output stalls and the verdict. Depends on jscan_pkg, the block itself and
// jscan_beat_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_jtag_ir_dr_scan_builder;
    import jscan_pkg::*;

    localparam int   MAX_SEQ     = 4096;
    localparam int   ITEMS       = 950;
    localparam int   QUIET_ITEMS = 150;
    localparam int   LONG_HOLD   = 300;
    localparam int   CYCLE_LIMIT = 400000;
    localparam logic SCAN_DR     = 1'b0;
    localparam logic SCAN_IR     = 1'b1;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              func        = SCAN_DR;
    logic [LEN_W-1:0]  seq_bits    = '0;
    logic [WORD_W-1:0] data_word   = '0;
    logic              tdo_capture = 1'b0;
    logic              send_now    = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [WORD_W-1:0] tms_word;
    logic [WORD_W-1:0] tdi_word;
    logic [POS_W-1:0]  word_pos;
    logic [LEN_W-1:0]  total_bits;
    logic [SKIP_W-1:0] tdo_skip;
    logic [LEN_W-1:0]  tdo_count;
    logic              flush_now;
    logic              last;

    int   fail_count;
    int   beats_pending;
    int   cycle_count   = 0;
    int   words_sent    = 0;
    int   random_target = 0;
    int   idle_odds     = 3;
    logic random_phase  = 1'b0;
    logic quiet         = 1'b0;

    jtag_ir_dr_scan_builder #(
        .MAX_SEQ_BITS (MAX_SEQ)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .seq_bits    (seq_bits),
        .data_word   (data_word),
        .tdo_capture (tdo_capture),
        .send_now    (send_now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tms_word    (tms_word),
        .tdi_word    (tdi_word),
        .word_pos    (word_pos),
        .total_bits  (total_bits),
        .tdo_skip    (tdo_skip),
        .tdo_count   (tdo_count),
        .flush_now   (flush_now),
        .last        (last)
    );

    jscan_beat_checker #(
        .MAX_LEN (MAX_SEQ)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .seq_bits      (seq_bits),
        .data_word     (data_word),
        .tdo_capture   (tdo_capture),
        .send_now      (send_now),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tms_word      (tms_word),
        .tdi_word      (tdi_word),
        .word_pos      (word_pos),
        .total_bits    (total_bits),
        .tdo_skip      (tdo_skip),
        .tdo_count     (tdo_count),
        .flush_now     (flush_now),
        .last          (last),
        .fail_count    (fail_count),
        .beats_pending (beats_pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one data word and returns at the edge where it is taken.
    task automatic send_word(input logic ir, input logic [LEN_W-1:0] len,
                             input logic [WORD_W-1:0] data, input logic rb,
                             input logic sn);
        if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= ir;
        seq_bits    <= len;
        data_word   <= data;
        tdo_capture <= rb;
        send_now    <= sn;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        words_sent++;
    endtask

    task automatic wait_for_beats();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly short scans; a few long ones and lengths outside the legal range.
    function automatic logic [LEN_W-1:0] pick_scan_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62)
        begin
            return LEN_W'($urandom_range(1, 64));
        end
        else if (r < 85)
        begin
            return LEN_W'($urandom_range(65, 320));
        end
        else if (r < 95)
        begin
            return LEN_W'($urandom_range(321, 1024));
        end
        else if (r < 97)
        begin
            return LEN_W'($urandom_range(1025, MAX_SEQ));
        end
        else if (r < 99)
        begin
            return '0;
        end
        return LEN_W'($urandom_range(MAX_SEQ + 1, 8191));
    endfunction

    // A broken scan stops early and may change its length between words.
    task automatic send_random_scan();
        logic             ir;
        logic             rb;
        logic             sn;
        logic             broken;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] word_len;
        int               eff_len;
        int               n_words;
        ir      = ($urandom_range(0, 1) == 1) ? SCAN_IR : SCAN_DR;
        rb      = 1'($urandom_range(0, 1));
        sn      = 1'($urandom_range(0, 1));
        len     = pick_scan_len();
        broken  = $urandom_range(0, 99) < 15;
        eff_len = (len == '0) ? 1 : ((int'(len) > MAX_SEQ) ? MAX_SEQ : int'(len));
        n_words = (eff_len + 31) / 32;
        idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);
        if (broken)
        begin
            n_words = $urandom_range(1, n_words);
        end
        for (int i = 0; i < n_words; i++)
        begin
            word_len = (broken && $urandom_range(0, 2) == 0) ? LEN_W'($urandom) : len;
            send_word(ir, word_len, $urandom, rb, sn);
        end
    endtask

    // Output side: short random stalls, one long hold at the start of the
    // random part so that the block backs up, and no stalls in the last part.
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (random_phase && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Single-word scans around the word boundary of the tail.
        send_word(SCAN_DR, 13'd1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(SCAN_IR, 13'd1, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(SCAN_DR, 13'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(SCAN_DR, 13'd26, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(SCAN_DR, 13'd27, 32'h0000_0000, 1'b0, 1'b0);
        send_word(SCAN_DR, 13'd27, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(SCAN_IR, 13'd25, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(SCAN_IR, 13'd32, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // Multi-word scans with carried bits.
        send_word(SCAN_DR, 13'd33, 32'hA5A5_A5A5, 1'b1, 1'b0);
        send_word(SCAN_DR, 13'd33, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(SCAN_IR, 13'd64, 32'h0000_0000, 1'b0, 1'b0);
        send_word(SCAN_IR, 13'd64, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // Length cut mid-scan so that the counter is already past the data.
        send_word(SCAN_DR, 13'd100, 32'h1234_5678, 1'b1, 1'b0);
        send_word(SCAN_DR, 13'd100, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(SCAN_DR, 13'd10, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // Length shortened so that the second word becomes the final one.
        send_word(SCAN_IR, 13'd100, 32'hDEAD_BEEF, 1'b0, 1'b0);
        send_word(SCAN_IR, 13'd40, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // Lengths above the maximum, then a cut to a single bit.
        send_word(SCAN_DR, 13'd8191, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(SCAN_DR, 13'd4097, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(SCAN_DR, 13'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        wait_for_beats();

        random_phase  <= 1'b1;
        random_target = words_sent + ITEMS;
        while (words_sent < random_target)
        begin
            if (words_sent >= random_target - QUIET_ITEMS)
            begin
                quiet <= 1'b1;
            end
            send_random_scan();
        end
        wait_for_beats();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && beats_pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/jscan_pkg.sv
sv/jscan_front.sv
sv/jscan_fifo.sv
sv/jscan_back.sv
sv/jtag_ir_dr_scan_builder.sv
tb/jscan_beat_checker.sv
tb/tb_jtag_ir_dr_scan_builder.sv
